### design/spisfd_pkg.sv
// Shared types and constants for the SPI register slave frame decoder.
package spisfd_pkg;

  localparam int REG_BYTES = 64;
  localparam int TX_BYTES  = 2048;
  localparam int REG_AW    = $clog2(REG_BYTES);
  localparam int TX_AW     = $clog2(TX_BYTES);
  localparam int IDX_W     = (TX_AW > REG_AW) ? TX_AW : REG_AW;
  localparam int CLR_DEPTH = (TX_BYTES > REG_BYTES) ? TX_BYTES : REG_BYTES;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [4:0]  BLK_SOCKET = 5'd1;
  localparam logic [4:0]  BLK_TX     = 5'd2;

  localparam logic [15:0] ADDR_CMD = 16'h0001;
  localparam logic [15:0] ADDR_W1C = 16'h0002;

  localparam logic [REG_AW-1:0] SOCK_IR_IDX = REG_AW'(2);
  localparam logic [REG_AW-1:0] SOCK_SR_IDX = REG_AW'(3);

  localparam logic [7:0] CMD_OPEN = 8'h01;
  localparam logic [7:0] CMD_RECV = 8'h20;
  localparam logic [7:0] SR_INIT  = 8'h22;
  localparam logic [7:0] IR_RECV  = 8'h10;

  typedef enum logic [3:0] {
    PH_ADDR_HI = 4'b0001,
    PH_ADDR_LO = 4'b0010,
    PH_CTRL    = 4'b0100,
    PH_DATA    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    OP_ZERO  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_COMMON = 2'd0,
    ST_SOCKET = 2'd1,
    ST_TX     = 2'd2
  } store_e;

  typedef enum logic [2:0] {
    SRC_ZERO   = 3'd0,
    SRC_COMMON = 3'd1,
    SRC_SOCKET = 3'd2,
    SRC_TX     = 3'd3,
    SRC_FLOP   = 3'd4
  } src_e;

  typedef struct packed {
    op_kind_e         kind;
    store_e           store;
    logic [IDX_W-1:0] idx;
    logic             addr_cmd;
    logic             addr_w1c;
    logic [7:0]       data;
  } op_t;

endpackage

### design/spisfd_front.sv
// Front end: frame phase tracking, header capture and data op classification.
module spisfd_front import spisfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] tx_byte_i,
  input  logic       clr_busy_i,
  input  logic       q_full_i,
  output logic       push_o,
  output op_t        op_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] addr_q, addr_d;
  logic [4:0]  blk_q, blk_d;
  logic        wr_q, wr_d;
  logic        accept;

  assign in_stall_o = clr_busy_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = accept & mode_i;

  always_comb begin
    phase_d     = phase_q;
    addr_d      = addr_q;
    blk_d       = blk_q;
    wr_d        = wr_q;
    op_o.kind   = OP_ZERO;
    op_o.store  = ST_COMMON;
    op_o.idx    = IDX_W'(addr_q[REG_AW-1:0]);
    op_o.addr_cmd = (addr_q == ADDR_CMD);
    op_o.addr_w1c = (addr_q == ADDR_W1C);
    op_o.data   = tx_byte_i;

    if (blk_q == BLK_TX) begin
      op_o.store = ST_TX;
      op_o.idx   = IDX_W'(addr_q[TX_AW-1:0]);
    end else if (blk_q == BLK_SOCKET) begin
      op_o.store = ST_SOCKET;
    end

    case (phase_q)
      PH_ADDR_HI: begin
        addr_d  = {tx_byte_i, 8'h00};
        phase_d = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        addr_d  = addr_q | {8'h00, tx_byte_i};
        phase_d = PH_CTRL;
      end
      PH_CTRL: begin
        blk_d   = tx_byte_i[7:3];
        wr_d    = tx_byte_i[2];
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        op_o.kind = wr_q ? OP_WRITE : OP_READ;
        addr_d    = addr_q + 16'd1;
      end
      default: begin
        phase_d = PH_ADDR_HI;
      end
    endcase

    // frame start only rewinds the header phase
    if (!mode_i) begin
      phase_d = PH_ADDR_HI;
      addr_d  = addr_q;
      blk_d   = blk_q;
      wr_d    = wr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR_HI;
      addr_q  <= 16'h0000;
      blk_q   <= 5'd0;
      wr_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      blk_q   <= blk_d;
      wr_q    <= wr_d;
    end
  end

  a_frame_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mode_i) |=> (phase_q == PH_ADDR_HI))
    else $error("phase not rewound after frame start");

endmodule

### design/spisfd_queue.sv
// Small FIFO of classified ops between front and back.
module spisfd_queue import spisfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  head_o
);

  op_t            mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

### design/spisfd_back.sv
// Back end: store access, socket side effects, clearing pass and result register.
module spisfd_back import spisfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       clr_busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] rx_byte_o
);

  // common / socket / transmit memories
  logic [7:0] c_mem [REG_BYTES];
  logic [7:0] s_mem [REG_BYTES];
  logic [7:0] t_mem [TX_BYTES];

  logic              c_we, c_re, s_we, s_re, t_we, t_re;
  logic [REG_AW-1:0] c_wa, c_ra, s_wa, s_ra;
  logic [TX_AW-1:0]  t_wa, t_ra;
  logic [7:0]        c_wd, s_wd, t_wd;
  logic [7:0]        c_rd_q, s_rd_q, t_rd_q;

  // socket bytes 2 and 3 live in flops: they take side-effect writes
  logic [7:0] ir_q, ir_d, sr_q, sr_d;

  logic [IDX_W-1:0] clr_q;
  logic             clr_busy_q;

  logic       p1_valid_q;
  src_e       p1_src_q, p1_src_d;
  logic [7:0] p1_flop_q, p1_flop_d;
  logic       out_valid_q;
  logic [7:0] out_data_q, out_data_d;

  logic              advance, p1_free;
  logic [REG_AW-1:0] reg_idx;
  logic [TX_AW-1:0]  tx_idx;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign p1_free    = ~p1_valid_q | advance;
  assign pop_o      = ~empty_i & ~clr_busy_q & p1_free;
  assign clr_busy_o = clr_busy_q;
  assign reg_idx    = head_i.idx[REG_AW-1:0];
  assign tx_idx     = head_i.idx[TX_AW-1:0];

  always_comb begin
    c_we = 1'b0; c_re = 1'b0; c_wa = reg_idx; c_ra = reg_idx; c_wd = head_i.data;
    s_we = 1'b0; s_re = 1'b0; s_wa = reg_idx; s_ra = reg_idx; s_wd = head_i.data;
    t_we = 1'b0; t_re = 1'b0; t_wa = tx_idx;  t_ra = tx_idx;  t_wd = head_i.data;
    ir_d      = ir_q;
    sr_d      = sr_q;
    p1_src_d  = SRC_ZERO;
    p1_flop_d = 8'h00;

    if (clr_busy_q) begin
      c_we = 1'b1; c_wa = clr_q[REG_AW-1:0]; c_wd = 8'h00;
      s_we = 1'b1; s_wa = clr_q[REG_AW-1:0]; s_wd = 8'h00;
      t_we = 1'b1; t_wa = clr_q[TX_AW-1:0];  t_wd = 8'h00;
    end else if (pop_o) begin
      case (head_i.kind)
        OP_WRITE: begin
          case (head_i.store)
            ST_TX:     t_we = 1'b1;
            ST_SOCKET: begin
              if (reg_idx == SOCK_IR_IDX) begin
                // write-one-to-clear only at the exact address
                ir_d = head_i.addr_w1c ? (ir_q & ~head_i.data) : head_i.data;
              end else if (reg_idx == SOCK_SR_IDX) begin
                sr_d = head_i.data;
              end else begin
                s_we = 1'b1;
              end
              if (head_i.addr_cmd) begin
                if (head_i.data == CMD_OPEN) begin
                  sr_d = SR_INIT;
                end else if (head_i.data == CMD_RECV) begin
                  ir_d = ir_q | IR_RECV;
                end
              end
            end
            default:   c_we = 1'b1;
          endcase
        end
        OP_READ: begin
          case (head_i.store)
            ST_TX: begin
              t_re     = 1'b1;
              p1_src_d = SRC_TX;
            end
            ST_SOCKET: begin
              if (reg_idx == SOCK_IR_IDX) begin
                p1_src_d  = SRC_FLOP;
                p1_flop_d = ir_q;
              end else if (reg_idx == SOCK_SR_IDX) begin
                p1_src_d  = SRC_FLOP;
                p1_flop_d = sr_q;
              end else begin
                s_re     = 1'b1;
                p1_src_d = SRC_SOCKET;
              end
            end
            default: begin
              c_re     = 1'b1;
              p1_src_d = SRC_COMMON;
            end
          endcase
        end
        default: p1_src_d = SRC_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (c_re) c_rd_q <= c_mem[c_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) s_mem[s_wa] <= s_wd;
    if (s_re) s_rd_q <= s_mem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) t_mem[t_wa] <= t_wd;
    if (t_re) t_rd_q <= t_mem[t_ra];
  end

  always_comb begin
    case (p1_src_q)
      SRC_COMMON: out_data_d = c_rd_q;
      SRC_SOCKET: out_data_d = s_rd_q;
      SRC_TX:     out_data_d = t_rd_q;
      SRC_FLOP:   out_data_d = p1_flop_q;
      default:    out_data_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      clr_busy_q  <= 1'b1;
      ir_q        <= 8'h00;
      sr_q        <= 8'h00;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_q <= clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(CLR_DEPTH - 1)) clr_busy_q <= 1'b0;
      end
      ir_q <= ir_d;
      sr_q <= sr_d;
      if (p1_free) p1_valid_q <= pop_o;
      if (advance) out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p1_src_q  <= p1_src_d;
      p1_flop_q <= p1_flop_d;
    end
    if (advance && p1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rx_byte_o   = out_data_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pop_o)
    else $error("op issued during clearing pass");

  a_p1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !advance) |=> (p1_valid_q && $stable(p1_src_q)))
    else $error("read stage lost while output stalled");

endmodule

### design/spi_register_slave_frame_decoder.sv
// Top level of the SPI register slave frame decoder.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------
//  in      | in  | in_valid_i/in_stall_o | mode_i, tx_byte_i
//  out     | out | out_valid_o/out_stall_i | rx_byte_o
//
// Sustained rate: one transaction per cycle while in_stall_o is low; the back
// end does one store access per popped op (a read and a write port per
// memory). A byte's result passes from the queue (written at the accepting
// edge) through the read stage to the output register.
// After reset, a clearing pass zeroes the stores over CLR_DEPTH addresses (2048
// by default, set by the transmit buffer); in_stall_o is high throughout.
// Frame starts (mode 0) give no result. Output stalls back up through the
// 4-entry queue before in_stall_o rises.
module spi_register_slave_frame_decoder import spisfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] rx_byte_o
);

  // front -> queue
  logic push;
  op_t  push_op;
  logic q_full;
  // queue -> back
  logic pop;
  logic q_empty;
  op_t  head_op;
  // clearing pass in progress
  logic clr_busy;

  // header decode and op classification
  spisfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .tx_byte_i  (tx_byte_i),
    .clr_busy_i (clr_busy),
    .q_full_i   (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decouples header decode from store access
  spisfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_op)
  );

  // store access, socket side effects, result register
  spisfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rx_byte_o   (rx_byte_o)
  );

endmodule
